>>> rtl/core/mtt_pkg.sv
// Shared types and constants for the markup tag tokenizer.
// Holds the parser state record, the per-byte result record, mode and code names.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

  // Limits on the saturating counters
  localparam logic [7:0] KEYWORD_MAX = 8'd128;
  localparam logic [8:0] OPTION_MAX  = 9'd256;

  // Known keyword names, lower case, right-justified in 8 bytes
  localparam int NUM_NAMES = 9;
  localparam int NAME_ASX      = 0;
  localparam int NAME_ENTRY    = 1;
  localparam int NAME_REF      = 2;
  localparam int NAME_ENTRYREF = 3;
  localparam int NAME_ASF      = 4;
  localparam int NAME_HTTP     = 5;
  localparam int NAME_MMS      = 6;
  localparam int NAME_MMST     = 7;
  localparam int NAME_MMSU     = 8;

  localparam logic [63:0] NAME_TEXT [NUM_NAMES] = '{
    64'("asx"), 64'("entry"), 64'("ref"), 64'("entryref"), 64'("asf"),
    64'("http"), 64'("mms"), 64'("mmst"), 64'("mmsu")
  };
  localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
    4'd3, 4'd5, 4'd3, 4'd8, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4
  };

  // Option name looked for on the first option
  localparam logic [31:0] HREF_TEXT = "href";
  localparam logic [2:0]  HREF_LEN  = 3'd4;
  localparam logic [2:0]  HREF_DONE = 3'd7;

  // Character roles
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_KEYWORD = 2'd1;
  localparam logic [1:0] KIND_OPTION  = 2'd2;
  localparam logic [1:0] KIND_ARG     = 2'd3;

  // Keyword classes
  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_ASX   = 2'd1;
  localparam logic [1:0] CLS_ENTRY = 2'd2;
  localparam logic [1:0] CLS_REF   = 2'd3;

  // File type codes
  localparam logic [1:0] FT_NONE  = 2'd0;
  localparam logic [1:0] FT_INI   = 2'd1;
  localparam logic [1:0] FT_PLAIN = 2'd2;

  typedef enum logic [3:0] {
    MODE_DETECT      = 4'd0,
    MODE_SEEK        = 4'd1,
    MODE_OPEN        = 4'd2,
    MODE_KEYWORD     = 4'd3,
    MODE_SPACE       = 4'd4,
    MODE_OPTNAME     = 4'd5,
    MODE_AFTER_NAME  = 4'd6,
    MODE_VALUE_START = 4'd7,
    MODE_VALUE       = 4'd8,
    MODE_QUOTED      = 4'd9,
    MODE_CLOSE       = 4'd10
  } parse_mode_t;

  typedef struct packed {
    parse_mode_t parse_mode;
    logic        skip_white;
    logic        closing_seen;
    logic [7:0]  keyword_length;
    logic [8:0]  keyword_match_bits;
    logic [8:0]  option_count;
    logic [2:0]  href_progress;
    logic        href_still_matching;
    logic        first_has_argument;
    logic [1:0]  decided_type;
  } state_t;

  typedef struct packed {
    logic [1:0] char_kind;
    logic [7:0] char_value;
    logic [7:0] option_index;
    logic       tag_done;
    logic       closing_tag;
    logic [1:0] keyword_class;
    logic       href_ready;
    logic       syntax_error;
    logic [1:0] file_type;
  } result_t;

  localparam state_t STATE_RESET = '{
    parse_mode:          MODE_DETECT,
    skip_white:          1'b1,
    closing_seen:        1'b0,
    keyword_length:      8'd0,
    keyword_match_bits:  9'h1FF,
    option_count:        9'd0,
    href_progress:       3'd0,
    href_still_matching: 1'b1,
    first_has_argument:  1'b0,
    decided_type:        FT_NONE
  };

endpackage

`default_nettype wire

>>> rtl/core/mtt_if.sv
// Valid/ready channel interfaces for the markup tag tokenizer.
// mtt_in_if carries one input byte beat, mtt_out_if one result beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

interface mtt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] char_kind;
  logic [7:0] char_value;
  logic [7:0] option_index;
  logic       tag_done;
  logic       closing_tag;
  logic [1:0] keyword_class;
  logic       href_ready;
  logic       syntax_error;
  logic [1:0] file_type;

  modport source (output valid, char_kind, char_value, option_index, tag_done,
                  closing_tag, keyword_class, href_ready, syntax_error, file_type,
                  input ready);
  modport sink   (input valid, char_kind, char_value, option_index, tag_done,
                  closing_tag, keyword_class, href_ready, syntax_error, file_type,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/mtt_step.sv
// Per-byte transition of the tag tokenizer: next parser state and the result beat.
// Purely combinational; the registers live in the top level.
// Depends on mtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtt_step (
  input  mtt_pkg::state_t  state,
  input  logic [7:0]       data_byte,
  input  logic             end_of_input,
  output mtt_pkg::state_t  state_next,
  output mtt_pkg::result_t res
);
  import mtt_pkg::*;

  // Drop keyword names that disagree with the character at the current position
  function automatic logic [8:0] kw_bits_add(input logic [7:0] len, input logic [8:0] bits,
                                             input logic [7:0] low);
    logic [8:0] b;
    logic [2:0] pos;
    b = bits;
    for (int i = 0; i < NUM_NAMES; i++) begin
      pos = 3'(NAME_LEN[i] - 4'd1 - len[3:0]);
      if (len >= {4'd0, NAME_LEN[i]}) begin
        b[i] = 1'b0;
      end else if (NAME_TEXT[i][8*pos +: 8] != low) begin
        b[i] = 1'b0;
      end
    end
    return b;
  endfunction

  function automatic logic kw_is(input state_t s, input int i);
    return s.keyword_match_bits[i] && (s.keyword_length == {4'd0, NAME_LEN[i]});
  endfunction

  logic       is_ws, is_alpha, is_lt, is_gt, is_slash, is_eq, is_quote, is_lbr;
  logic [7:0] low;
  logic       plain_hit;
  state_t     n;
  logic [1:0] kind;
  logic       done, err, kw_add_en;
  logic       run_seek, run_kw, run_opt, run_after, run_val;
  logic [1:0] cls;
  logic       href;

  // Classify the byte; the end mark counts as whitespace and matches nothing else
  always_comb begin
    low      = data_byte | 8'h20;
    is_ws    = end_of_input || data_byte == " " || data_byte == 8'h09 ||
               data_byte == 8'h0D || data_byte == 8'h0A;
    is_alpha = !end_of_input && low >= "a" && low <= "z";
    is_lt    = !end_of_input && data_byte == "<";
    is_gt    = !end_of_input && data_byte == ">";
    is_slash = !end_of_input && data_byte == "/";
    is_eq    = !end_of_input && data_byte == "=";
    is_quote = !end_of_input && data_byte == 8'h22;
    is_lbr   = !end_of_input && data_byte == "[";
    plain_hit = kw_is(state, NAME_ASF) || kw_is(state, NAME_HTTP) ||
                kw_is(state, NAME_MMS) || kw_is(state, NAME_MMST) ||
                kw_is(state, NAME_MMSU);
  end

  // Next state: mode dispatch, with later modes reached by fall-through flags
  always_comb begin
    n         = state;
    kind      = KIND_NONE;
    done      = 1'b0;
    err       = 1'b0;
    kw_add_en = 1'b0;
    run_seek  = 1'b0;
    run_kw    = 1'b0;
    run_opt   = 1'b0;
    run_after = 1'b0;
    run_val   = 1'b0;

    if (state.decided_type == FT_NONE && !(state.skip_white && is_ws)) begin
      case (state.parse_mode)
        MODE_DETECT: begin
          if (is_lt) begin
            run_seek = 1'b1;
          end else if (is_lbr) begin
            n.decided_type = FT_INI;
          end else if (is_alpha) begin
            kw_add_en    = 1'b1;
            kind         = KIND_KEYWORD;
            n.skip_white = 1'b0;
          end else if (plain_hit) begin
            n.decided_type = FT_PLAIN;
          end else begin
            err = 1'b1;
          end
        end
        MODE_SEEK: begin
          run_seek = 1'b1;
        end
        MODE_OPEN: begin
          if (is_slash) begin
            n.closing_seen = 1'b1;
          end else if (!is_alpha) begin
            err = 1'b1;
          end else begin
            n.parse_mode = MODE_KEYWORD;
            n.skip_white = 1'b0;
            run_kw       = 1'b1;
          end
        end
        MODE_KEYWORD: begin
          run_kw = 1'b1;
        end
        MODE_SPACE: begin
          if (is_slash) begin
            n.closing_seen = 1'b1;
            n.parse_mode   = MODE_CLOSE;
            n.skip_white   = 1'b1;
          end else if (is_gt) begin
            done = 1'b1;
          end else if (!is_alpha) begin
            err = 1'b1;
          end else begin
            // Open a new option; close out href tracking of the first one
            if (n.option_count != 9'd0 && n.href_progress != HREF_DONE) begin
              if (n.href_progress != HREF_LEN) n.href_still_matching = 1'b0;
              n.href_progress = HREF_DONE;
            end
            if (n.option_count < OPTION_MAX) n.option_count = n.option_count + 9'd1;
            n.parse_mode = MODE_OPTNAME;
            n.skip_white = 1'b0;
            run_opt      = 1'b1;
          end
        end
        MODE_OPTNAME: begin
          run_opt = 1'b1;
        end
        MODE_AFTER_NAME: begin
          run_after = 1'b1;
        end
        MODE_VALUE_START: begin
          if (is_quote) begin
            n.parse_mode = MODE_QUOTED;
            n.skip_white = 1'b0;
          end else if (is_slash) begin
            err = 1'b1;
          end else begin
            n.parse_mode = MODE_VALUE;
            n.skip_white = 1'b1;
            run_val      = !is_ws;
          end
        end
        MODE_VALUE: begin
          run_val = 1'b1;
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            n.parse_mode = MODE_SPACE;
            n.skip_white = 1'b1;
          end else if (!end_of_input) begin
            kind = KIND_ARG;
          end
        end
        MODE_CLOSE: begin
          if (is_gt) done = 1'b1;
          else       err  = 1'b1;
        end
        default: begin
          run_seek = 1'b1;
        end
      endcase

      // Bracket search: restart the tag record on '<'
      if (run_seek && is_lt) begin
        n.closing_seen        = 1'b0;
        n.keyword_length      = 8'd0;
        n.keyword_match_bits  = 9'h1FF;
        n.option_count        = 9'd0;
        n.href_progress       = 3'd0;
        n.href_still_matching = 1'b1;
        n.first_has_argument  = 1'b0;
        n.parse_mode          = MODE_OPEN;
        n.skip_white          = 1'b1;
      end

      // Keyword characters
      if (run_kw) begin
        if (is_ws) begin
          n.parse_mode = MODE_SPACE;
          n.skip_white = 1'b1;
        end else if (is_alpha) begin
          kw_add_en = 1'b1;
          kind      = KIND_KEYWORD;
        end else if (is_slash) begin
          n.closing_seen = 1'b1;
          n.parse_mode   = MODE_CLOSE;
          n.skip_white   = 1'b1;
        end else if (is_gt) begin
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end

      // Option name characters; track "href" on the first option
      if (run_opt) begin
        if (is_alpha) begin
          kind = KIND_OPTION;
          if (n.option_count != 9'd0 && n.href_progress != HREF_DONE) begin
            if (n.href_progress < HREF_LEN &&
                low == HREF_TEXT[8*(2'd3 - n.href_progress[1:0]) +: 8]) begin
              n.href_progress = n.href_progress + 3'd1;
            end else begin
              n.href_still_matching = 1'b0;
            end
          end
        end else begin
          n.parse_mode = MODE_AFTER_NAME;
          n.skip_white = 1'b1;
          run_after    = !is_ws;
        end
      end

      // After an option name
      if (run_after) begin
        if (is_slash) begin
          n.closing_seen = 1'b1;
          n.parse_mode   = MODE_CLOSE;
          n.skip_white   = 1'b1;
        end else if (is_gt) begin
          done = 1'b1;
        end else if (is_eq) begin
          if (n.option_count != 9'd0 && n.href_progress != HREF_DONE) begin
            n.first_has_argument = 1'b1;
          end
          n.parse_mode = MODE_VALUE_START;
          n.skip_white = 1'b1;
        end else begin
          err = 1'b1;
        end
      end

      // Unquoted argument characters
      if (run_val) begin
        if (is_quote || is_eq) begin
          err = 1'b1;
        end else if (is_ws) begin
          n.parse_mode = MODE_SPACE;
          n.skip_white = 1'b1;
        end else if (is_slash) begin
          n.closing_seen = 1'b1;
          n.parse_mode   = MODE_CLOSE;
          n.skip_white   = 1'b1;
        end else if (is_gt) begin
          done = 1'b1;
        end else begin
          kind         = KIND_ARG;
          n.skip_white = 1'b0;
        end
      end

      // Advance the keyword match with saturation of its length
      if (kw_add_en) begin
        n.keyword_match_bits = kw_bits_add(n.keyword_length, n.keyword_match_bits, low);
        if (n.keyword_length < KEYWORD_MAX) n.keyword_length = n.keyword_length + 8'd1;
      end

      // Finished tag or syntax error: back to the bracket search
      if (done || err) begin
        n.parse_mode = MODE_SEEK;
        n.skip_white = 1'b1;
      end
    end
  end

  assign state_next = n;

  // Result beat: classify the finished tag and pass the byte through
  always_comb begin
    cls  = CLS_OTHER;
    href = 1'b0;
    if (done) begin
      if (kw_is(n, NAME_ASX))        cls = CLS_ASX;
      else if (kw_is(n, NAME_ENTRY)) cls = CLS_ENTRY;
      else if (kw_is(n, NAME_REF) || kw_is(n, NAME_ENTRYREF)) cls = CLS_REF;
      href = (cls == CLS_REF) && n.option_count != 9'd0 && n.href_still_matching &&
             (n.href_progress == HREF_LEN || n.href_progress == HREF_DONE) &&
             n.first_has_argument;
    end
    res.char_kind     = kind;
    res.char_value    = (kind != KIND_NONE) ? data_byte : 8'd0;
    res.option_index  = (n.option_count != 9'd0) ? 8'(n.option_count - 9'd1) : 8'd0;
    res.tag_done      = done;
    res.closing_tag   = done && n.closing_seen;
    res.keyword_class = cls;
    res.href_ready    = href;
    res.syntax_error  = err;
    res.file_type     = n.decided_type;
  end

endmodule

`default_nettype wire

>>> rtl/core/markup_tag_tokenizer.sv
// Markup tag tokenizer top level: input register, parser state, result register.
// Depends on mtt_pkg, mtt_if (mtt_in_if, mtt_out_if) and mtt_step.
//
// Usage:
//   in_ch carries one text byte per beat (data_byte, end_of_input); an
//   end-of-input beat counts as whitespace and its byte is ignored.
//   out_ch returns exactly one result beat per input beat, in order.
//   An accepted byte is loaded into the input register, then passes through
//   the per-byte transition into the result register, from which out_ch
//   takes it; while out_ch stalls, the byte waits in the input register.
//   Throughput is one byte per cycle while out_ch does not stall; the parser
//   state register is the only loop.
//   When out_ch stalls, the result register holds its beat and the input
//   register holds the next byte; in_ch.ready drops only once both are full.
//   Synchronous reset empties both registers and returns the parser to file
//   type detection with whitespace skipping on. Once an INI or plain file is
//   detected, every later result carries only that file type until reset.
`timescale 1ns / 1ps
`default_nettype none

module markup_tag_tokenizer (
  input  wire logic  clk,
  input  wire logic  rst,
  mtt_in_if.sink     in_ch,
  mtt_out_if.source  out_ch
);
  import mtt_pkg::*;

  logic       in_valid;
  logic [7:0] in_data_byte;
  logic       in_end_of_input;
  logic       out_valid;
  result_t    out_q;
  state_t     state;
  state_t     state_next;
  result_t    step_res;
  logic       advance;

  // Move a byte into the result stage when the result register is free
  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;

  mtt_step u_step (
    .state        (state),
    .data_byte    (in_data_byte),
    .end_of_input (in_end_of_input),
    .state_next   (state_next),
    .res          (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_byte    <= in_ch.data_byte;
      in_end_of_input <= in_ch.end_of_input;
    end
  end

  // Parser state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.char_kind     = out_q.char_kind;
  assign out_ch.char_value    = out_q.char_value;
  assign out_ch.option_index  = out_q.option_index;
  assign out_ch.tag_done      = out_q.tag_done;
  assign out_ch.closing_tag   = out_q.closing_tag;
  assign out_ch.keyword_class = out_q.keyword_class;
  assign out_ch.href_ready    = out_q.href_ready;
  assign out_ch.syntax_error  = out_q.syntax_error;
  assign out_ch.file_type     = out_q.file_type;

  // A detected file type never changes until reset
  a_type_sticky: assert property (@(posedge clk) disable iff (rst)
    state.decided_type != FT_NONE |=> state.decided_type == $past(state.decided_type))
    else $error("file type changed after detection");

  // A finished tag and a syntax error never come from the same byte
  a_done_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_q.tag_done && out_q.syntax_error))
    else $error("tag done together with syntax error");

  // href ready only on a finished Ref-class tag
  a_href: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.href_ready |-> out_q.tag_done && out_q.keyword_class == CLS_REF)
    else $error("href ready without a finished Ref tag");

  // The keyword length saturates
  a_kw_len: assert property (@(posedge clk) disable iff (rst)
    state.keyword_length <= KEYWORD_MAX)
    else $error("keyword length beyond saturation");

endmodule

`default_nettype wire

>>> verif/tag_stream_checker.sv
// Result checker for the markup tag tokenizer testbench.
// Watches both channels, predicts one result per input beat and compares in order.
// Depends on mtt_pkg and the channel interfaces in mtt_if.
`timescale 1ns / 1ps

module tag_stream_checker (
  input  wire logic clk,
  input  wire logic rst,
  mtt_in_if         in_ch,
  mtt_out_if        out_ch,
  output int        mismatches,
  output int        expected_left,
  output int        tags_closed,
  output int        errors_seen
);
  import mtt_pkg::*;

  // Known keyword spellings, lower case, in package name order
  string name_word [NUM_NAMES] = '{
    "asx", "entry", "ref", "entryref", "asf", "http", "mms", "mmst", "mmsu"
  };
  string href_word = "href";

  // Predicted parser state
  logic [3:0] mode;
  logic       skip_ws;
  logic       slash_seen;
  logic [7:0] kw_len;
  logic [8:0] kw_hits;
  logic [8:0] opt_cnt;
  logic [2:0] href_pos;
  logic       href_ok;
  logic       first_arg;
  logic [1:0] ftype;

  result_t expected_tokens [$];
  result_t want;
  int      fail_tally = 0;
  int      done_tally = 0;
  int      err_tally = 0;
  int      beats_checked = 0;

  // Count one mismatch and print one line for it
  task automatic flag_mismatch(input string what, input int got, input int wanted);
    $display("MISMATCH at %0t, result %0d, %s: got %0d, want %0d",
             $time, beats_checked, what, got, wanted);
    fail_tally++;
  endtask

  // Append one keyword letter and drop names that no longer fit
  function automatic void keyword_push(input logic [7:0] ch);
    logic [7:0] low;
    int         i;
    low = ch | 8'h20;
    for (i = 0; i < NUM_NAMES; i++) begin
      if (kw_len >= name_word[i].len() || name_word[i][kw_len] != low)
        kw_hits[i] = 1'b0;
    end
    if (kw_len < KEYWORD_MAX)
      kw_len++;
  endfunction

  function automatic logic keyword_is(input int idx);
    return kw_hits[idx] && kw_len == name_word[idx].len();
  endfunction

  // Advance the predicted parser by one beat and return its result
  function automatic result_t tokenize_byte(input logic [7:0] b, input logic eof);
    result_t    r;
    logic       ws, alpha, lt, gt, sl, eq, qt, lb;
    logic       done, err, again;
    logic [1:0] kind;
    logic [3:0] m;
    r = '0;
    kind = KIND_NONE;
    done = 1'b0;
    err = 1'b0;
    ws = eof || b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A;
    alpha = !eof && ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z"));
    lt = !eof && b == "<";
    gt = !eof && b == ">";
    sl = !eof && b == "/";
    eq = !eof && b == "=";
    qt = !eof && b == "\"";
    lb = !eof && b == "[";

    if (ftype == FT_NONE && !(skip_ws && ws)) begin
      m = mode;
      again = 1'b1;
      // walk the mode chain; some modes hand the same byte on to the next
      while (again) begin
        again = 1'b0;
        case (m)
          MODE_DETECT: begin
            if (lt) begin
              m = MODE_SEEK;
              again = 1'b1;
            end else if (lb) begin
              ftype = FT_INI;
            end else if (alpha) begin
              keyword_push(b);
              kind = KIND_KEYWORD;
              skip_ws = 1'b0;
            end else if (keyword_is(NAME_ASF) || keyword_is(NAME_HTTP) ||
                         keyword_is(NAME_MMS) || keyword_is(NAME_MMST) ||
                         keyword_is(NAME_MMSU)) begin
              ftype = FT_PLAIN;
            end else begin
              err = 1'b1;
            end
          end
          MODE_OPEN: begin
            if (sl) begin
              slash_seen = 1'b1;
            end else if (!alpha) begin
              err = 1'b1;
            end else begin
              mode = MODE_KEYWORD;
              skip_ws = 1'b0;
              m = MODE_KEYWORD;
              again = 1'b1;
            end
          end
          MODE_KEYWORD: begin
            if (ws) begin
              mode = MODE_SPACE;
              skip_ws = 1'b1;
            end else if (alpha) begin
              keyword_push(b);
              kind = KIND_KEYWORD;
            end else if (sl) begin
              slash_seen = 1'b1;
              mode = MODE_CLOSE;
              skip_ws = 1'b1;
            end else if (gt) begin
              done = 1'b1;
            end else begin
              err = 1'b1;
            end
          end
          MODE_SPACE: begin
            if (sl) begin
              slash_seen = 1'b1;
              mode = MODE_CLOSE;
              skip_ws = 1'b1;
            end else if (gt) begin
              done = 1'b1;
            end else if (!alpha) begin
              err = 1'b1;
            end else begin
              // a new option closes the href check on the first one
              if (opt_cnt >= 1 && href_pos != HREF_DONE) begin
                if (href_pos != HREF_LEN)
                  href_ok = 1'b0;
                href_pos = HREF_DONE;
              end
              if (opt_cnt < OPTION_MAX)
                opt_cnt++;
              mode = MODE_OPTNAME;
              skip_ws = 1'b0;
              m = MODE_OPTNAME;
              again = 1'b1;
            end
          end
          MODE_OPTNAME: begin
            if (alpha) begin
              if (opt_cnt >= 1 && href_pos != HREF_DONE) begin
                if (href_pos < HREF_LEN && (b | 8'h20) == href_word[href_pos])
                  href_pos++;
                else
                  href_ok = 1'b0;
              end
              kind = KIND_OPTION;
            end else begin
              mode = MODE_AFTER_NAME;
              skip_ws = 1'b1;
              if (!ws) begin
                m = MODE_AFTER_NAME;
                again = 1'b1;
              end
            end
          end
          MODE_AFTER_NAME: begin
            if (sl) begin
              slash_seen = 1'b1;
              mode = MODE_CLOSE;
              skip_ws = 1'b1;
            end else if (gt) begin
              done = 1'b1;
            end else if (eq) begin
              if (opt_cnt >= 1 && href_pos != HREF_DONE)
                first_arg = 1'b1;
              mode = MODE_VALUE_START;
              skip_ws = 1'b1;
            end else begin
              err = 1'b1;
            end
          end
          MODE_VALUE_START: begin
            if (qt) begin
              mode = MODE_QUOTED;
              skip_ws = 1'b0;
            end else if (sl) begin
              err = 1'b1;
            end else begin
              mode = MODE_VALUE;
              skip_ws = 1'b1;
              if (!ws) begin
                m = MODE_VALUE;
                again = 1'b1;
              end
            end
          end
          MODE_VALUE: begin
            if (qt || eq) begin
              err = 1'b1;
            end else if (ws) begin
              mode = MODE_SPACE;
              skip_ws = 1'b1;
            end else if (sl) begin
              slash_seen = 1'b1;
              mode = MODE_CLOSE;
              skip_ws = 1'b1;
            end else if (gt) begin
              done = 1'b1;
            end else begin
              kind = KIND_ARG;
              skip_ws = 1'b0;
            end
          end
          MODE_QUOTED: begin
            if (qt) begin
              mode = MODE_SPACE;
              skip_ws = 1'b1;
            end else if (!eof) begin
              kind = KIND_ARG;
            end
          end
          MODE_CLOSE: begin
            if (gt)
              done = 1'b1;
            else
              err = 1'b1;
          end
          default: begin
            // bracket search: a '<' starts a fresh tag
            if (lt) begin
              slash_seen = 1'b0;
              kw_len = '0;
              kw_hits = '1;
              opt_cnt = '0;
              href_pos = '0;
              href_ok = 1'b1;
              first_arg = 1'b0;
              mode = MODE_OPEN;
              skip_ws = 1'b1;
            end
          end
        endcase
      end

      // Classify a finished tag
      if (done) begin
        r.closing_tag = slash_seen;
        if (keyword_is(NAME_ASX))
          r.keyword_class = CLS_ASX;
        else if (keyword_is(NAME_ENTRY))
          r.keyword_class = CLS_ENTRY;
        else if (keyword_is(NAME_REF) || keyword_is(NAME_ENTRYREF))
          r.keyword_class = CLS_REF;
        r.href_ready = r.keyword_class == CLS_REF && opt_cnt >= 1 && href_ok &&
                       (href_pos == HREF_LEN || href_pos == HREF_DONE) && first_arg;
        mode = MODE_SEEK;
        skip_ws = 1'b1;
      end
      if (err) begin
        mode = MODE_SEEK;
        skip_ws = 1'b1;
      end
    end

    r.char_kind = kind;
    r.char_value = (kind != KIND_NONE) ? b : 8'd0;
    r.option_index = (opt_cnt != 0) ? 8'(opt_cnt - 1) : 8'd0;
    r.tag_done = done;
    r.syntax_error = err;
    r.file_type = ftype;
    return r;
  endfunction

  // Check result beats in order, then queue a prediction for each input beat
  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_DETECT;
      skip_ws = 1'b1;
      slash_seen = 1'b0;
      kw_len = '0;
      kw_hits = '1;
      opt_cnt = '0;
      href_pos = '0;
      href_ok = 1'b1;
      first_arg = 1'b0;
      ftype = FT_NONE;
      expected_tokens.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          flag_mismatch("result beat with nothing expected", 0, 0);
        end else begin
          want = expected_tokens.pop_front();
          if (out_ch.char_kind != want.char_kind)
            flag_mismatch("char_kind", out_ch.char_kind, want.char_kind);
          if (out_ch.char_value != want.char_value)
            flag_mismatch("char_value", out_ch.char_value, want.char_value);
          if (out_ch.option_index != want.option_index)
            flag_mismatch("option_index", out_ch.option_index, want.option_index);
          if (out_ch.tag_done != want.tag_done)
            flag_mismatch("tag_done", out_ch.tag_done, want.tag_done);
          if (out_ch.closing_tag != want.closing_tag)
            flag_mismatch("closing_tag", out_ch.closing_tag, want.closing_tag);
          if (out_ch.keyword_class != want.keyword_class)
            flag_mismatch("keyword_class", out_ch.keyword_class, want.keyword_class);
          if (out_ch.href_ready != want.href_ready)
            flag_mismatch("href_ready", out_ch.href_ready, want.href_ready);
          if (out_ch.syntax_error != want.syntax_error)
            flag_mismatch("syntax_error", out_ch.syntax_error, want.syntax_error);
          if (out_ch.file_type != want.file_type)
            flag_mismatch("file_type", out_ch.file_type, want.file_type);
          if (want.tag_done)
            done_tally++;
          if (want.syntax_error)
            err_tally++;
        end
        beats_checked++;
      end
      if (in_ch.valid && in_ch.ready)
        expected_tokens.push_back(tokenize_byte(in_ch.data_byte, in_ch.end_of_input));
    end
    mismatches <= fail_tally;
    expected_left <= expected_tokens.size();
    tags_closed <= done_tally;
    errors_seen <= err_tally;
  end

endmodule

>>> verif/markup_tag_tokenizer_tb.sv
// Testbench top for the markup tag tokenizer.
// Drives tag text beats, stalls the result side, and reports the checker's verdict.
// Depends on mtt_pkg, mtt_if, the tokenizer RTL and tag_stream_checker.
`timescale 1ns / 1ps

module markup_tag_tokenizer_tb;
  import mtt_pkg::*;

  logic clk = 1'b0;
  logic rst;

  mtt_in_if  in_ch ();
  mtt_out_if out_ch ();

  int mismatches;
  int expected_left;
  int tags_closed;
  int errors_seen;

  markup_tag_tokenizer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tag_stream_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .expected_left (expected_left),
    .tags_closed   (tags_closed),
    .errors_seen   (errors_seen)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Text waiting to be sent: bit 8 marks end of input
  logic [8:0] text_beats [$];
  int         tx_max = 5;
  int         beats_sent = 0;
  int         end_marks = 0;

  string tag_names [] = '{
    "asx", "entry", "ref", "entryref", "ref", "entryref", "asf", "http", "mms",
    "mmst", "mmsu", "entr", "refs", "asxx", "entryre", "re"
  };
  string href_like [] = '{"href", "href", "href", "hre", "hrefs", "h", "hreff"};
  string breakers = "<>/=\" [";

  task automatic put_char(input logic [7:0] c);
    text_beats.push_back({1'b0, c});
  endtask

  task automatic put_end();
    text_beats.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  // Push a word, flipping letter case at random when asked
  task automatic put_word(input string s, input bit mixed);
    logic [7:0] c;
    int         i;
    for (i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixed && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
          $urandom_range(0, 1) == 1)
        c = c ^ 8'h20;
      put_char(c);
    end
  endtask

  task automatic put_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1)
      c = c ^ 8'h20;
    put_char(c);
  endtask

  task automatic put_space();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: put_char(" ");
      4:       put_char(8'h09);
      5:       put_char(8'h0D);
      6:       put_char(8'h0A);
      default: put_end();
    endcase
  endtask

  // Unquoted argument byte: any byte above space except quote, '=', '/' and '>'
  task automatic put_bare();
    logic [7:0] c;
    do
      c = 8'($urandom_range(33, 255));
    while (c == "\"" || c == "=" || c == "/" || c == ">");
    put_char(c);
  endtask

  // Quoted argument byte: anything but the quote, sometimes an end mark
  task automatic put_quoted();
    logic [7:0] c;
    if ($urandom_range(0, 11) == 0) begin
      put_end();
    end else begin
      do
        c = 8'($urandom_range(0, 255));
      while (c == "\"");
      put_char(c);
    end
  endtask

  // Build one tag with random content; some get broken afterwards
  task automatic build_tag(input bit long_keyword, input int forced_opts);
    int n_opts, k, start, pick;
    if (forced_opts == 0 && !long_keyword && $urandom_range(0, 3) == 0)
      put_char(8'($urandom_range(0, 255)));
    start = text_beats.size();
    put_char("<");
    if ($urandom_range(0, 3) == 0)
      put_space();
    if ($urandom_range(0, 5) == 0)
      put_char("/");
    if (long_keyword) begin
      put_word("entryref", 1);
      repeat (125) put_letter();
    end else if ($urandom_range(0, 2) != 0) begin
      put_word(tag_names[$urandom_range(0, tag_names.size() - 1)], 1);
    end else begin
      repeat ($urandom_range(1, 9)) put_letter();
    end

    if (forced_opts != 0)
      n_opts = forced_opts;
    else
      n_opts = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
    for (k = 0; k < n_opts; k++) begin
      put_space();
      // Shortest valid option: one-letter name with a one-letter value
      if (forced_opts != 0) begin
        put_letter();
        put_char("=");
        put_letter();
        continue;
      end
      if ($urandom_range(0, 1) == 1)
        put_space();
      if (k == 0 && $urandom_range(0, 2) != 0)
        put_word(href_like[$urandom_range(0, href_like.size() - 1)], 1);
      else
        repeat ($urandom_range(1, 6)) put_letter();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) == 0)
          put_space();
        put_char("=");
        if ($urandom_range(0, 4) == 0)
          put_space();
        if ($urandom_range(0, 1) == 1) begin
          put_char("\"");
          repeat ($urandom_range(0, 6)) put_quoted();
          put_char("\"");
        end else begin
          repeat ($urandom_range(1, 6)) put_bare();
        end
      end
    end

    // Terminate with '>', ' >', '/>' or '/ >'
    pick = $urandom_range(0, 3);
    if (pick == 0)
      put_space();
    if (pick >= 2) begin
      put_char("/");
      if (pick == 3)
        put_space();
    end
    put_char(">");

    // Break some tags: overwrite one beat, or cut the tail off
    pick = (forced_opts != 0 || long_keyword) ? 9 : $urandom_range(0, 9);
    if (pick == 0) begin
      k = $urandom_range(start, text_beats.size() - 1);
      text_beats[k] = {1'b0, breakers[$urandom_range(0, breakers.len() - 1)]};
    end else if (pick == 1) begin
      k = $urandom_range(start, text_beats.size() - 1);
      text_beats[k] = {1'b0, 8'($urandom_range(0, 255))};
    end else if (pick == 2) begin
      repeat ($urandom_range(1, 3))
        if (text_beats.size() > start + 1)
          void'(text_beats.pop_back());
    end
  endtask

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [8:0] beat);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= beat[7:0];
    in_ch.end_of_input <= beat[8];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    if (beat[8])
      end_marks++;
  endtask

  task automatic send_text();
    while (text_beats.size() != 0)
      send_beat(text_beats.pop_front());
  endtask

  // Result side: random stalls per beat, one long hold-off to back up the input
  int rx_wait;
  int rx_hold;
  int rx_taken;
  int rx_max;
  int rx_draw;

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
        rx_wait = 0;
        rx_hold = 0;
        rx_taken = 0;
        rx_max = 0;
      end else if (rx_hold != 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else if (out_ch.valid && out_ch.ready) begin
        rx_taken++;
        if (rx_taken % 64 == 0)
          rx_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 19);
        if (rx_taken == 300) begin
          out_ch.ready <= 1'b0;
          rx_hold = 400;
        end else begin
          rx_draw = $urandom_range(0, rx_max);
          out_ch.ready <= (rx_draw == 0);
          rx_wait = (rx_draw == 0) ? 0 : rx_draw - 1;
        end
      end else if (!out_ch.ready) begin
        if (rx_wait == 0)
          out_ch.ready <= 1'b1;
        else
          rx_wait--;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int tag_no;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'd0;
    in_ch.end_of_input <= 1'b0;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: skipped whitespace and keyword letters before the first tag,
    // '<' taking precedence over a plain keyword, an href tag, a bad keyword
    // start, an end mark and a zero byte while searching for '<'
    put_word("\n mMs<Ref HREF=\"a\">", 0);
    put_word("</", 0);
    put_char(8'hFF);
    put_end();
    put_char(8'h00);
    send_text();

    // Random tags; one tag past the option limit and one overlong keyword first
    tag_no = 0;
    while (beats_sent < 1350) begin
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      build_tag(tag_no == 1, (tag_no == 0) ? 258 : 0);
      send_text();
      tag_no++;
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow for the input and result registers
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d beats (%0d end marks) in %0d random tags; %0d tags closed, %0d errors.",
             beats_sent, end_marks, tag_no, tags_closed, errors_seen);
    $display("Included an overlong keyword, 258 options, and a 400-cycle output hold-off.");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected", expected_left);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
